/* hdl/srov_pkg.sv */
// shared types and constants for the segment raster overlap counter
package srov_pkg;

	localparam int COORD_W = 10;
	localparam int LEN_W   = COORD_W + 1;
	localparam int TOTAL_W = 21;
	localparam int MARK_W  = 4;
	localparam int CNT_W   = 2;

	localparam logic [CNT_W-1:0] CNT_ONE = 2'd1;
	localparam logic [CNT_W-1:0] CNT_SAT = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
	} seg_t;

	typedef struct packed {
		logic               accepted;
		logic [TOTAL_W-1:0] straight_overlaps;
		logic [TOTAL_W-1:0] all_overlaps;
	} res_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_BASE,
		S_RUN,
		S_DRAIN,
		S_DONE
	} state_t;

	// one saturating count step
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		sat_inc = (c < CNT_SAT) ? c + CNT_ONE : c;
	endfunction

endpackage

/* hdl/srov_seg_if.sv */
// segment input channel
interface srov_seg_if;
	logic          valid;
	logic          ready;
	srov_pkg::seg_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/srov_res_if.sv */
// result output channel
interface srov_res_if;
	logic          valid;
	logic          ready;
	srov_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/segment_raster_overlap_counter.sv */
// Segment raster overlap counter: top level with the grid memory and its read-modify-write loop.
// Each segment transaction yields one result transaction. After reset the block first clears
// every cell of the grid, one cell a cycle, and takes no segment until then.
// A drawn segment is walked one cell per cycle, set by the single read port and single write
// port of the grid memory (each cell is read, then modified and written back the next cycle,
// overlapped along the segment), with setup states CHECK and BASE before the walk and DRAIN
// and DONE after it. A rejected segment goes from CHECK straight to DONE. The next segment is taken
// while a result still waits on the output; the block holds only when a second result is ready.
module segment_raster_overlap_counter #(
	parameter int GRID_DIM = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	srov_seg_if.sink   seg,
	srov_res_if.source res
);

	localparam int CELLS = GRID_DIM * GRID_DIM;
	localparam int AW    = $clog2(CELLS);
	localparam logic [AW-1:0] SIDE_A    = AW'(GRID_DIM);
	localparam logic [AW-1:0] ONE_A     = AW'(1);
	localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
	localparam logic [srov_pkg::LEN_W-1:0] LEN_ONE = srov_pkg::LEN_W'(1);

	// grid memory: straight count in bits 1:0, any-kind count in bits 3:2
	logic [srov_pkg::MARK_W-1:0] grid_mem [CELLS];
	logic [srov_pkg::MARK_W-1:0] rd_data_s1;

	srov_pkg::state_t state_q, state_nx;

	srov_pkg::seg_t                 seg_q;
	logic                           straight_q;
	logic                           ok_q;
	logic [srov_pkg::LEN_W-1:0]     cnt_q;
	logic [AW-1:0]                  addr_q;
	logic [AW-1:0]                  step_q;
	logic [AW-1:0]                  row_base_q;
	logic                           valid_s1;
	logic                           straight_s1;
	logic [AW-1:0]                  addr_s1;
	logic [srov_pkg::TOTAL_W-1:0]   straight_total_q;
	logic [srov_pkg::TOTAL_W-1:0]   overall_total_q;
	logic                           out_valid_q;
	srov_pkg::res_t                 out_data_q;

	// control decoded from the state
	logic take_seg;
	logic rd_en;
	logic clr_en;
	logic load_out;

	// segment checks
	logic                        x_fwd, x_back, y_fwd, y_back;
	logic [srov_pkg::COORD_W-1:0] adx, ady, span;
	logic                        in_range, straight_c, ok_c;
	logic [AW-1:0]               step_c;

	// cell update
	logic [srov_pkg::CNT_W-1:0]  s_old, a_old, s_new, a_new;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [srov_pkg::MARK_W-1:0] wr_data;

	always_comb begin
		x_fwd  = seg_q.end_x > seg_q.start_x;
		x_back = seg_q.end_x < seg_q.start_x;
		y_fwd  = seg_q.end_y > seg_q.start_y;
		y_back = seg_q.end_y < seg_q.start_y;
		adx = x_fwd ? seg_q.end_x - seg_q.start_x : seg_q.start_x - seg_q.end_x;
		ady = y_fwd ? seg_q.end_y - seg_q.start_y : seg_q.start_y - seg_q.end_y;
		span = (adx > ady) ? adx : ady;
		in_range = (32'(seg_q.start_x) < 32'(GRID_DIM)) && (32'(seg_q.start_y) < 32'(GRID_DIM))
			&& (32'(seg_q.end_x) < 32'(GRID_DIM)) && (32'(seg_q.end_y) < 32'(GRID_DIM));
		straight_c = !x_fwd && !x_back || !y_fwd && !y_back;
		ok_c = in_range && (straight_c || adx == ady);
		step_c = '0;
		if (y_fwd) begin
			step_c = SIDE_A;
		end else if (y_back) begin
			step_c = -SIDE_A;
		end
		if (x_fwd) begin
			step_c = step_c + ONE_A;
		end else if (x_back) begin
			step_c = step_c - ONE_A;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			srov_pkg::S_CLEAR: begin
				if (addr_q == CELL_LAST) state_nx = srov_pkg::S_IDLE;
			end
			srov_pkg::S_IDLE: begin
				if (seg.valid) state_nx = srov_pkg::S_CHECK;
			end
			srov_pkg::S_CHECK: begin
				state_nx = ok_c ? srov_pkg::S_BASE : srov_pkg::S_DONE;
			end
			srov_pkg::S_BASE: begin
				state_nx = srov_pkg::S_RUN;
			end
			srov_pkg::S_RUN: begin
				if (cnt_q == LEN_ONE) state_nx = srov_pkg::S_DRAIN;
			end
			srov_pkg::S_DRAIN: begin
				state_nx = srov_pkg::S_DONE;
			end
			srov_pkg::S_DONE: begin
				if (!out_valid_q || res.ready) state_nx = srov_pkg::S_IDLE;
			end
			default: begin
				state_nx = srov_pkg::S_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		take_seg = 1'b0;
		rd_en    = 1'b0;
		clr_en   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			srov_pkg::S_CLEAR: clr_en = 1'b1;
			srov_pkg::S_IDLE:  take_seg = 1'b1;
			srov_pkg::S_RUN:   rd_en = 1'b1;
			srov_pkg::S_DONE:  load_out = !out_valid_q || res.ready;
			default: begin
				take_seg = 1'b0;
			end
		endcase
	end

	assign seg.ready = take_seg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srov_pkg::S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// segment setup and address walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (clr_en) begin
				addr_q <= addr_q + ONE_A;
			end else if (state_q == srov_pkg::S_BASE) begin
				addr_q <= row_base_q + AW'(seg_q.start_x);
			end else if (rd_en) begin
				addr_q <= addr_q + step_q;
			end
			if (state_q == srov_pkg::S_CHECK) begin
				cnt_q <= {1'b0, span} + LEN_ONE;
			end else if (rd_en) begin
				cnt_q <= cnt_q - LEN_ONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_seg && seg.valid) begin
			seg_q <= seg.data;
		end
		if (state_q == srov_pkg::S_CHECK) begin
			straight_q <= straight_c;
			ok_q       <= ok_c;
			step_q     <= step_c;
			row_base_q <= AW'(AW'(seg_q.start_y) * SIDE_A);
		end
	end

	// grid memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			grid_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= grid_mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1     <= addr_q;
		straight_s1 <= straight_q;
	end

	// modify and write back; cells along one segment are distinct
	always_comb begin
		s_old = rd_data_s1[srov_pkg::CNT_W-1:0];
		a_old = rd_data_s1[srov_pkg::MARK_W-1:srov_pkg::CNT_W];
		s_new = straight_s1 ? srov_pkg::sat_inc(s_old) : s_old;
		a_new = srov_pkg::sat_inc(a_old);
		wr_en   = clr_en || valid_s1;
		wr_addr = clr_en ? addr_q : addr_s1;
		wr_data = clr_en ? '0 : {a_new, s_new};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			straight_total_q <= '0;
			overall_total_q  <= '0;
		end else if (valid_s1) begin
			if (straight_s1 && s_old == srov_pkg::CNT_ONE) begin
				straight_total_q <= straight_total_q + srov_pkg::TOTAL_W'(1);
			end
			if (a_old == srov_pkg::CNT_ONE) begin
				overall_total_q <= overall_total_q + srov_pkg::TOTAL_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q.accepted          <= ok_q;
			out_data_q.straight_overlaps <= straight_total_q;
			out_data_q.all_overlaps      <= overall_total_q;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_data_q;

endmodule
